// ===== rtl/ksto_pkg.sv =====
// ----------------------------------------------------------------------------
// ksto_pkg
// shared types, widths and codes of the keyed slot table
// ----------------------------------------------------------------------------
package ksto_pkg;

    // fixed field widths
    localparam int KEY_W     = 56;
    localparam int KEY_EXT_W = 64;
    localparam int STAMP_W   = 32;
    localparam int LEN_W     = 8;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // parameter defaults
    localparam int DEF_SLOTS    = 20;
    localparam int DEF_KEY_BITS = 56;

    localparam logic [STAMP_W-1:0] STAMP_BOUND = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0]   MIN_LEN_RST = 8'd100;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST = 8'd166;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 8'd1;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
        logic [LEN_W-1:0]   length;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  found_len;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_item;

    // search token handed from cell to cell
    typedef struct packed {
        logic               act;
        logic               hit;
        logic [STAMP_W-1:0] stamp;
        logic [LEN_W-1:0]   len;
    } t_probe;

    // broadcast write into one cell
    typedef struct packed {
        logic               en;
        logic [STAMP_W-1:0] stamp;
        logic [LEN_W-1:0]   len;
    } t_wr;

endpackage

// ===== rtl/ksto_in_if.sv =====
// ----------------------------------------------------------------------------
// ksto_in_if
// request channel: valid, ready and one request item
// ----------------------------------------------------------------------------
interface ksto_in_if;
    logic              valid;
    logic              ready;
    ksto_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ksto_out_if.sv =====
// ----------------------------------------------------------------------------
// ksto_out_if
// response channel: valid, ready and one response item
// ----------------------------------------------------------------------------
interface ksto_out_if;
    logic               valid;
    logic               ready;
    ksto_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ksto_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ksto_cfg_if
// register write channel: valid, ready, index and write data
// ----------------------------------------------------------------------------
interface ksto_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ksto_pkg::CFG_IDX_W-1:0]       index;
    logic [ksto_pkg::CFG_DAT_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ksto_cell.sv =====
// ----------------------------------------------------------------------------
// ksto_cell
// one table slot: holds key, stamp and length, updates the passing token
// ----------------------------------------------------------------------------
module ksto_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = ksto_pkg::DEF_KEY_BITS,
    parameter int IDX_W    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  ksto_pkg::t_probe    i_probe,
    input  logic [IDX_W-1:0]    i_idx,
    input  ksto_pkg::t_wr       i_wr,
    input  logic [IDX_W-1:0]    i_wr_idx,
    output ksto_pkg::t_probe    o_probe,
    output logic [IDX_W-1:0]    o_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [KEY_BITS-1:0]            r_key;
    logic [ksto_pkg::STAMP_W-1:0]   r_stamp;
    logic [ksto_pkg::LEN_W-1:0]     r_len;
    ksto_pkg::t_probe               r_probe;
    ksto_pkg::t_probe               n_probe;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               n_idx;

    always_comb begin
        n_probe = i_probe;
        n_idx   = i_idx;
        if (i_probe.act && !i_probe.hit) begin
            if (r_key == i_key) begin
                n_probe.hit = 1'b1;
                n_probe.len = r_len;
                n_idx       = MY_IDX;
            end else if (r_stamp < i_probe.stamp) begin
                n_probe.stamp = r_stamp;
                n_idx         = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_stamp <= '0;
            r_len   <= '0;
            r_probe <= '0;
            r_idx   <= '0;
        end else begin
            r_probe <= n_probe;
            r_idx   <= n_idx;
            if (i_wr.en && (i_wr_idx == MY_IDX)) begin
                r_key   <= i_key;
                r_stamp <= i_wr.stamp;
                r_len   <= i_wr.len;
            end
        end
    end

    assign o_probe = r_probe;
    assign o_idx   = r_idx;

endmodule

// ===== rtl/keyed_slot_table_oldest_eviction.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table_oldest_eviction
// fully associative record table with oldest-timestamp replacement
// ----------------------------------------------------------------------------
// The table is a row of SLOTS cells, one per slot, each holding a key prefix,
// a timestamp and a length, all zero after reset. A request item (get or put)
// launches a search token into cell 0; the token moves one cell per clock and
// each cell folds in its own slot: first key match wins, otherwise the token
// keeps the lowest-indexed strictly smallest timestamp (slot 0 as fallback).
// When the token leaves the last cell the response is built and a put that
// passes the min_len/max_len check writes key, stamp and length into the
// chosen slot. From acceptance to the next acceptance an item passes a launch
// step, one hop per cell, a result step and a write/response step, the last
// waiting while an untaken response fills the output register. The response
// sits in an output register, so a new request is taken while it waits.
// Register writes (index 0 min_len, index 1 max_len, others ignored) are
// always ready and should only happen while the table is idle.
// ----------------------------------------------------------------------------
module keyed_slot_table_oldest_eviction #(
    parameter int SLOTS    = ksto_pkg::DEF_SLOTS,
    parameter int KEY_BITS = ksto_pkg::DEF_KEY_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ksto_in_if.sink         i_in,
    ksto_out_if.source      o_out,
    ksto_cfg_if.sink        i_cfg
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;

    // latched request item
    logic                         r_func;
    logic [KEY_BITS-1:0]          r_key;
    logic [ksto_pkg::STAMP_W-1:0] r_stamp;
    logic [ksto_pkg::LEN_W-1:0]   r_len;
    logic                         r_inject;

    // config registers
    logic [ksto_pkg::LEN_W-1:0]   r_min;
    logic [ksto_pkg::LEN_W-1:0]   r_max;

    // search result captured from the end of the chain
    logic                         r_hit;
    logic [IDX_W-1:0]             r_pick;
    logic [ksto_pkg::LEN_W-1:0]   r_flen;

    // response register
    logic                         r_out_valid;
    ksto_pkg::t_out_item          r_out;
    ksto_pkg::t_out_item          n_out;

    ksto_pkg::t_probe             c_probe [0:SLOTS];
    logic [IDX_W-1:0]             c_idx   [0:SLOTS];
    ksto_pkg::t_wr                c_wr;

    logic                         in_acc;
    logic                         out_free;
    logic                         range_ok;
    logic                         res_ok;
    logic [ksto_pkg::KEY_EXT_W-1:0]      key_ext;
    logic [ksto_pkg::SLOT_W+IDX_W-1:0]   pick_ext;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // key zero-extended, then cut to the compared width
    assign key_ext  = {{(ksto_pkg::KEY_EXT_W-ksto_pkg::KEY_W){1'b0}}, i_in.data.key};
    assign pick_ext = {{ksto_pkg::SLOT_W{1'b0}}, r_pick};

    // token launched into cell 0
    assign c_probe[0] = '{act: r_inject, hit: 1'b0,
                          stamp: ksto_pkg::STAMP_BOUND, len: '0};
    assign c_idx[0]   = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ksto_cell #(
            .INDEX    (g),
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_key    (r_key),
            .i_probe  (c_probe[g]),
            .i_idx    (c_idx[g]),
            .i_wr     (c_wr),
            .i_wr_idx (r_pick),
            .o_probe  (c_probe[g+1]),
            .o_idx    (c_idx[g+1])
        );
    end

    // put length window; inverted bounds refuse everything
    assign range_ok = (r_len >= r_min) && (r_len <= r_max);
    assign res_ok   = (r_func == ksto_pkg::FUNC_PUT) ? range_ok : r_hit;

    always_comb begin
        n_out.ok        = res_ok;
        n_out.slot      = res_ok ? pick_ext[ksto_pkg::SLOT_W-1:0] : '0;
        n_out.found_len = '0;
        if (res_ok) begin
            n_out.found_len = (r_func == ksto_pkg::FUNC_PUT) ? r_len : r_flen;
        end
    end

    // write-back into the chosen slot, only for an accepted put
    always_comb begin
        c_wr.en    = (r_state == ST_DONE) && out_free &&
                     (r_func == ksto_pkg::FUNC_PUT) && range_ok;
        c_wr.stamp = r_stamp;
        c_wr.len   = r_len;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (c_probe[SLOTS].act) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= ksto_pkg::MIN_LEN_RST;
            r_max       <= ksto_pkg::MAX_LEN_RST;
        end else begin
            r_state  <= n_state;
            r_inject <= in_acc;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == ksto_pkg::REG_MIN_LEN) r_min <= i_cfg.data;
                if (i_cfg.index == ksto_pkg::REG_MAX_LEN) r_max <= i_cfg.data;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= i_in.data.func;
            r_key   <= key_ext[KEY_BITS-1:0];
            r_stamp <= i_in.data.stamp;
            r_len   <= i_in.data.length;
        end
        if ((r_state == ST_SCAN) && c_probe[SLOTS].act) begin
            r_hit  <= c_probe[SLOTS].hit;
            r_pick <= c_idx[SLOTS];
            r_flen <= c_probe[SLOTS].len;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out <= n_out;
        end
    end

    // token reaches the end of the row only during a search
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_probe[SLOTS].act |-> (r_state == ST_SCAN))
        else $error("search token left the row outside a search");

    // slot writes only come from a put
    a_write_is_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_wr.en |-> (r_func == ksto_pkg::FUNC_PUT))
        else $error("slot write without a put");

    // a refused or missed item reports slot 0 and length 0
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |-> ((r_out.slot == '0) && (r_out.found_len == '0)))
        else $error("failed item with nonzero slot or length");

    // an accepted item starts a search and launches the token
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == ST_SCAN) && r_inject))
        else $error("accepted item did not start a search");

endmodule
